// ===== src/ppc_pkg.sv =====
package ppc_pkg;

  localparam int unsigned MAX_QUBITS = 64;
  localparam int unsigned CODE_W     = 64;
  localparam int unsigned QCNT_W     = 7;
  localparam int unsigned WGT_W      = 32;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned SUM_W      = PROD_W + 1;
  localparam int unsigned PCNT_W     = 7;

  localparam logic FUNC_PRODUCT = 1'b0;
  localparam logic FUNC_COMMUTE = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_MISMATCH = 1'b1;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  typedef struct packed {
    logic [CODE_W-1:0] xr;
    logic [CODE_W-1:0] zr;
    logic [1:0]        phase;
    logic [1:0]        f;
    logic              commutes;
    logic              func;
    logic              mismatch;
  } code_res_t;

  typedef struct packed {
    logic signed [WGT_W-1:0] re;
    logic signed [WGT_W-1:0] im;
    logic                    sat;
  } wgt_res_t;

  function automatic logic [PCNT_W-1:0] popcount64(input logic [CODE_W-1:0] v);
    logic [1:0] c2  [32];
    logic [2:0] c4  [16];
    logic [3:0] c8  [8];
    logic [4:0] c16 [4];
    logic [5:0] c32 [2];
    for (int i = 0; i < 32; i++) begin
      c2[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      c4[i] = {1'b0, c2[2*i]} + {1'b0, c2[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      c8[i] = {1'b0, c4[2*i]} + {1'b0, c4[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      c16[i] = {1'b0, c8[2*i]} + {1'b0, c8[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      c32[i] = {1'b0, c16[2*i]} + {1'b0, c16[2*i+1]};
    end
    return {1'b0, c32[0]} + {1'b0, c32[1]};
  endfunction

endpackage

// ===== src/ppc_code_unit.sv =====
module ppc_code_unit
  import ppc_pkg::*;
(
  input  logic                 clk,
  input  stage_en_t            en,
  input  logic                 func,
  input  logic [QCNT_W-1:0]    qubits_a,
  input  logic [QCNT_W-1:0]    qubits_b,
  input  logic [CODE_W-1:0]    x_a,
  input  logic [CODE_W-1:0]    z_a,
  input  logic [CODE_W-1:0]    x_b,
  input  logic [CODE_W-1:0]    z_b,
  output code_res_t            res
);

  logic [CODE_W-1:0] mask_a;
  logic [CODE_W-1:0] mask_b;
  logic [CODE_W-1:0] xa_m;
  logic [CODE_W-1:0] za_m;
  logic [CODE_W-1:0] xb_m;
  logic [CODE_W-1:0] zb_m;

  logic [CODE_W-1:0] s1_xr_r;
  logic [CODE_W-1:0] s1_zr_r;
  logic [CODE_W-1:0] s1_aa_r;
  logic [CODE_W-1:0] s1_bb_r;
  logic [CODE_W-1:0] s1_ab_r;
  logic [CODE_W-1:0] s1_ba_r;
  logic              s1_func_r;
  logic              s1_mism_r;

  logic [CODE_W-1:0] s2_xr_r;
  logic [CODE_W-1:0] s2_zr_r;
  logic [1:0]        s2_pa_r;
  logic [1:0]        s2_pb_r;
  logic [1:0]        s2_pab_r;
  logic [1:0]        s2_pr_r;
  logic              s2_par_r;
  logic              s2_func_r;
  logic              s2_mism_r;

  logic [PCNT_W-1:0] pa;
  logic [PCNT_W-1:0] pb;
  logic [PCNT_W-1:0] pab;
  logic [PCNT_W-1:0] pr;

  code_res_t s3_r;

  always_comb begin
    for (int k = 0; k < CODE_W; k++) begin
      mask_a[k] = (QCNT_W'(k) < qubits_a) && (k < MAX_QUBITS);
      mask_b[k] = (QCNT_W'(k) < qubits_b) && (k < MAX_QUBITS);
    end
  end

  assign xa_m = x_a & mask_a;
  assign za_m = z_a & mask_a;
  assign xb_m = x_b & mask_b;
  assign zb_m = z_b & mask_b;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1_xr_r   <= xa_m ^ xb_m;
      s1_zr_r   <= za_m ^ zb_m;
      s1_aa_r   <= xa_m & za_m;
      s1_bb_r   <= xb_m & zb_m;
      s1_ab_r   <= xa_m & zb_m;
      s1_ba_r   <= za_m & xb_m;
      s1_func_r <= func;
      s1_mism_r <= (qubits_a != qubits_b);
    end
  end

  assign pa  = popcount64(s1_aa_r);
  assign pb  = popcount64(s1_bb_r);
  assign pab = popcount64(s1_ab_r);
  assign pr  = popcount64(s1_xr_r & s1_zr_r);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      s2_xr_r   <= s1_xr_r;
      s2_zr_r   <= s1_zr_r;
      s2_pa_r   <= pa[1:0];
      s2_pb_r   <= pb[1:0];
      s2_pab_r  <= pab[1:0];
      s2_pr_r   <= pr[1:0];
      s2_par_r  <= ^(s1_ab_r ^ s1_ba_r);
      s2_func_r <= s1_func_r;
      s2_mism_r <= s1_mism_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      s3_r.xr       <= s2_xr_r;
      s3_r.zr       <= s2_zr_r;
      s3_r.phase    <= s2_pr_r;
      s3_r.f        <= s2_pa_r + s2_pb_r + {s2_pab_r[0], 1'b0} - s2_pr_r;
      s3_r.commutes <= ~s2_par_r;
      s3_r.func     <= s2_func_r;
      s3_r.mismatch <= s2_mism_r;
    end
  end

  assign res = s3_r;

endmodule

// ===== src/ppc_weight_unit.sv =====
module ppc_weight_unit
  import ppc_pkg::*;
(
  input  logic                    clk,
  input  stage_en_t               en,
  input  logic signed [WGT_W-1:0] wa_re,
  input  logic signed [WGT_W-1:0] wa_im,
  input  logic signed [WGT_W-1:0] wb_re,
  input  logic signed [WGT_W-1:0] wb_im,
  output wgt_res_t                res
);

  localparam int unsigned RND_W = SUM_W + 1;
  localparam int unsigned SHR_W = RND_W - 16;
  localparam logic signed [SHR_W-1:0] W_MAX = SHR_W'(64'sd2147483647);
  localparam logic signed [SHR_W-1:0] W_MIN = -SHR_W'(64'sd2147483648);

  logic signed [PROD_W-1:0] p_rr_r;
  logic signed [PROD_W-1:0] p_ii_r;
  logic signed [PROD_W-1:0] p_ri_r;
  logic signed [PROD_W-1:0] p_ir_r;

  logic signed [SUM_W-1:0] s_re_r;
  logic signed [SUM_W-1:0] s_im_r;

  logic signed [RND_W-1:0] rnd_re;
  logic signed [RND_W-1:0] rnd_im;
  logic signed [SHR_W-1:0] sh_re;
  logic signed [SHR_W-1:0] sh_im;
  logic signed [WGT_W-1:0] cl_re;
  logic signed [WGT_W-1:0] cl_im;
  logic                    sat_re;
  logic                    sat_im;

  wgt_res_t s3_r;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      p_rr_r <= wa_re * wb_re;
      p_ii_r <= wa_im * wb_im;
      p_ri_r <= wa_re * wb_im;
      p_ir_r <= wa_im * wb_re;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      s_re_r <= {p_rr_r[PROD_W-1], p_rr_r} - {p_ii_r[PROD_W-1], p_ii_r};
      s_im_r <= {p_ri_r[PROD_W-1], p_ri_r} + {p_ir_r[PROD_W-1], p_ir_r};
    end
  end

  assign rnd_re = {s_re_r[SUM_W-1], s_re_r} + RND_W'(32768);
  assign rnd_im = {s_im_r[SUM_W-1], s_im_r} + RND_W'(32768);
  assign sh_re  = rnd_re[RND_W-1:16];
  assign sh_im  = rnd_im[RND_W-1:16];

  always_comb begin
    sat_re = 1'b0;
    cl_re  = sh_re[WGT_W-1:0];
    if (sh_re > W_MAX) begin
      sat_re = 1'b1;
      cl_re  = W_MAX[WGT_W-1:0];
    end else if (sh_re < W_MIN) begin
      sat_re = 1'b1;
      cl_re  = W_MIN[WGT_W-1:0];
    end
    sat_im = 1'b0;
    cl_im  = sh_im[WGT_W-1:0];
    if (sh_im > W_MAX) begin
      sat_im = 1'b1;
      cl_im  = W_MAX[WGT_W-1:0];
    end else if (sh_im < W_MIN) begin
      sat_im = 1'b1;
      cl_im  = W_MIN[WGT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      s3_r.re  <= cl_re;
      s3_r.im  <= cl_im;
      s3_r.sat <= sat_re | sat_im;
    end
  end

  assign res = s3_r;

endmodule

// ===== src/pauli_product_commute_alu.sv =====
// Pauli product and commutation unit for symplectic Pauli strings.
// The input channel (in_*) takes one beat per pair of weighted Pauli strings;
// in_tuser selects the product or the commutation test. The result channel
// (out_*) returns exactly one beat per input beat, in order.
// The unit is a four-stage pipeline: masking and the weight multipliers,
// population counts and the complex sums, rounding and clipping with the
// phase index, and finally the (-i)^f rotation in the output register.
// A result passes the s1, s2 and s3 registers and the output register before
// out_tvalid rises. While the receiver does not stall, the throughput is one
// beat per cycle. The four 32 by 32 bit multiplies and the 64-bit population
// counts each fill their own stage and set the clock period.
// When the receiver stalls, stages that hold data stop in place while empty
// stages still fill, so in_tready drops only once all four stages are full.
// Nothing is lost or repeated. Reset empties the pipeline; results in flight
// are discarded and in_tready is high right after reset.
module pauli_product_commute_alu
  import ppc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // From bit 0: qubits_a, qubits_b, x_a, z_a, x_b, z_b, wa_re, wa_im, wb_re,
  // wb_im, then zero fill.
  input  logic [399:0] in_tdata,
  // Bit 0: func.
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // From bit 0: x_out, z_out, phase_out, w_re_out, w_im_out, commutes,
  // saturated, then zero fill.
  output logic [199:0] out_tdata,
  // Bit 0: status.
  output logic         out_tuser
);

  logic v1_r;
  logic v2_r;
  logic v3_r;
  logic v4_r;
  logic en4;
  stage_en_t en;

  code_res_t code_res;
  wgt_res_t  wgt_res;

  logic [CODE_W-1:0]       x_out_r;
  logic [CODE_W-1:0]       z_out_r;
  logic [1:0]              phase_r;
  logic signed [WGT_W-1:0] w_re_r;
  logic signed [WGT_W-1:0] w_im_r;
  logic                    commutes_r;
  logic                    sat_r;
  logic                    status_r;

  logic [CODE_W-1:0]       x_out_nxt;
  logic [CODE_W-1:0]       z_out_nxt;
  logic [1:0]              phase_nxt;
  logic signed [WGT_W-1:0] w_re_nxt;
  logic signed [WGT_W-1:0] w_im_nxt;
  logic                    commutes_nxt;
  logic                    sat_nxt;
  logic                    status_nxt;

  logic signed [WGT_W-1:0] neg_re;
  logic signed [WGT_W-1:0] neg_im;
  logic                    neg_re_sat;
  logic                    neg_im_sat;
  logic signed [WGT_W-1:0] rot_re;
  logic signed [WGT_W-1:0] rot_im;
  logic                    rot_sat;

  localparam logic signed [WGT_W-1:0] W_MAX = {1'b0, {(WGT_W-1){1'b1}}};
  localparam logic signed [WGT_W-1:0] W_MIN = {1'b1, {(WGT_W-1){1'b0}}};

  assign en4   = ~v4_r | out_tready;
  assign en.s3 = ~v3_r | en4;
  assign en.s2 = ~v2_r | en.s3;
  assign en.s1 = ~v1_r | en.s2;
  assign in_tready = en.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_tvalid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en4)   v4_r <= v3_r;
    end
  end

  ppc_code_unit u_code (
    .clk      (clk),
    .en       (en),
    .func     (in_tuser),
    .qubits_a (in_tdata[6:0]),
    .qubits_b (in_tdata[13:7]),
    .x_a      (in_tdata[77:14]),
    .z_a      (in_tdata[141:78]),
    .x_b      (in_tdata[205:142]),
    .z_b      (in_tdata[269:206]),
    .res      (code_res)
  );

  ppc_weight_unit u_weight (
    .clk   (clk),
    .en    (en),
    .wa_re (in_tdata[301:270]),
    .wa_im (in_tdata[333:302]),
    .wb_re (in_tdata[365:334]),
    .wb_im (in_tdata[397:366]),
    .res   (wgt_res)
  );

  always_comb begin
    neg_re_sat = (wgt_res.re == W_MIN);
    neg_im_sat = (wgt_res.im == W_MIN);
    neg_re     = neg_re_sat ? W_MAX : -wgt_res.re;
    neg_im     = neg_im_sat ? W_MAX : -wgt_res.im;
    case (code_res.f)
      2'd0: begin
        rot_re  = wgt_res.re;
        rot_im  = wgt_res.im;
        rot_sat = wgt_res.sat;
      end
      2'd1: begin
        rot_re  = wgt_res.im;
        rot_im  = neg_re;
        rot_sat = wgt_res.sat | neg_re_sat;
      end
      2'd2: begin
        rot_re  = neg_re;
        rot_im  = neg_im;
        rot_sat = wgt_res.sat | neg_re_sat | neg_im_sat;
      end
      default: begin
        rot_re  = neg_im;
        rot_im  = wgt_res.re;
        rot_sat = wgt_res.sat | neg_im_sat;
      end
    endcase
  end

  always_comb begin
    x_out_nxt    = '0;
    z_out_nxt    = '0;
    phase_nxt    = '0;
    w_re_nxt     = '0;
    w_im_nxt     = '0;
    commutes_nxt = 1'b0;
    sat_nxt      = 1'b0;
    status_nxt   = STATUS_OK;
    if (code_res.mismatch) begin
      status_nxt = STATUS_MISMATCH;
    end else if (code_res.func == FUNC_COMMUTE) begin
      commutes_nxt = code_res.commutes;
    end else begin
      x_out_nxt = code_res.xr;
      z_out_nxt = code_res.zr;
      phase_nxt = code_res.phase;
      w_re_nxt  = rot_re;
      w_im_nxt  = rot_im;
      sat_nxt   = rot_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      x_out_r    <= x_out_nxt;
      z_out_r    <= z_out_nxt;
      phase_r    <= phase_nxt;
      w_re_r     <= w_re_nxt;
      w_im_r     <= w_im_nxt;
      commutes_r <= commutes_nxt;
      sat_r      <= sat_nxt;
      status_r   <= status_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {4'd0, sat_r, commutes_r, w_im_r, w_re_r, phase_r, z_out_r, x_out_r};
  assign out_tuser  = status_r;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ppc_pkg::*;

  localparam logic [31:0] W_ONE  = 32'h0001_0000;
  localparam logic [31:0] W_HALF = 32'h0000_8000;
  localparam logic [31:0] W_MAX  = 32'h7fff_ffff;
  localparam logic [31:0] W_MIN  = 32'h8000_0000;
  localparam logic [63:0] ONES   = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic        func;
    logic [6:0]  qubits_a;
    logic [6:0]  qubits_b;
    logic [63:0] x_a;
    logic [63:0] z_a;
    logic [63:0] x_b;
    logic [63:0] z_b;
    logic [31:0] wa_re;
    logic [31:0] wa_im;
    logic [31:0] wb_re;
    logic [31:0] wb_im;
  } pauli_pair_t;

  typedef struct packed {
    logic [63:0] x_out;
    logic [63:0] z_out;
    logic [1:0]  phase_out;
    logic [31:0] w_re_out;
    logic [31:0] w_im_out;
    logic        commutes;
    logic        saturated;
    logic        status;
  } pauli_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [399:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [199:0] out_tdata;
  logic         out_tuser;

  pauli_pair_t   pair_q[$];
  pauli_result_t product_q[$];
  pauli_result_t want;
  int            error_count = 0;
  int            in_wait = 0;
  int            out_wait = 0;
  bit            in_calm = 1'b0;
  bit            out_calm = 1'b0;

  pauli_product_commute_alu u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] qubit_mask(input logic [6:0] n);
    if (n >= MAX_QUBITS) return ONES;
    return (64'd1 << n) - 64'd1;
  endfunction

  // Bit 32 of the result flags a clip.
  function automatic logic [32:0] round_q16(input logic signed [65:0] s);
    logic signed [65:0] r;
    r = (s + 66'sd32768) >>> 16;
    if (r > 66'sd2147483647) return {1'b1, W_MAX};
    if (r < -66'sd2147483648) return {1'b1, W_MIN};
    return {1'b0, r[31:0]};
  endfunction

  function automatic logic [32:0] negate_q16(input logic [31:0] v);
    if (v == W_MIN) return {1'b1, W_MAX};
    return {1'b0, 32'd0 - v};
  endfunction

  function automatic pauli_result_t pauli_product(input pauli_pair_t p);
    pauli_result_t      r;
    logic [63:0]        xa, za, xb, zb;
    logic signed [65:0] s_re, s_im;
    logic [32:0]        re, im, ro, io;
    int                 pr, f;
    r = '0;
    xa = p.x_a & qubit_mask(p.qubits_a);
    za = p.z_a & qubit_mask(p.qubits_a);
    xb = p.x_b & qubit_mask(p.qubits_b);
    zb = p.z_b & qubit_mask(p.qubits_b);
    if (p.qubits_a != p.qubits_b) begin
      r.status = STATUS_MISMATCH;
      return r;
    end
    r.status = STATUS_OK;
    if (p.func == FUNC_COMMUTE) begin
      r.commutes = (($countones(xa & zb) + $countones(za & xb)) % 2) == 0;
      return r;
    end
    r.x_out = xa ^ xb;
    r.z_out = za ^ zb;
    pr = $countones(r.x_out & r.z_out);
    f = ($countones(xa & za) + $countones(xb & zb) + 2 * $countones(xa & zb)
         + 256 - pr) % 4;
    r.phase_out = pr[1:0];
    s_re = $signed(p.wa_re) * $signed(p.wb_re) - $signed(p.wa_im) * $signed(p.wb_im);
    s_im = $signed(p.wa_re) * $signed(p.wb_im) + $signed(p.wa_im) * $signed(p.wb_re);
    re = round_q16(s_re);
    im = round_q16(s_im);
    case (f)
      0: begin
        ro = re;
        io = im;
      end
      1: begin
        ro = im;
        io = negate_q16(re[31:0]);
      end
      2: begin
        ro = negate_q16(re[31:0]);
        io = negate_q16(im[31:0]);
      end
      default: begin
        ro = negate_q16(im[31:0]);
        io = re;
      end
    endcase
    r.w_re_out = ro[31:0];
    r.w_im_out = io[31:0];
    r.saturated = re[32] | im[32] | ro[32] | io[32];
    return r;
  endfunction

  function automatic int idle_draw(input bit calm);
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [63:0] rand_code();
    case ($urandom_range(0, 9))
      0: return ONES;
      1: return '0;
      2, 3: return {$urandom & $urandom, $urandom & $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return W_MIN;
      1: return W_MAX;
      2: return 32'hffff_ffff;
      3, 4, 5: return $urandom;
      default: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
    endcase
  endfunction

  task automatic add_pair(input logic func, input logic [6:0] qa, input logic [6:0] qb,
                          input logic [63:0] xa, input logic [63:0] za,
                          input logic [63:0] xb, input logic [63:0] zb,
                          input logic [31:0] ar, input logic [31:0] ai,
                          input logic [31:0] br, input logic [31:0] bi);
    pair_q.push_back('{func, qa, qb, xa, za, xb, zb, ar, ai, br, bi});
  endtask

  task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
    if (exp !== act) begin
      $error("%s: expected %h, got %h", name, exp, act);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        product_q.push_back(pauli_product(pair_q.pop_front()));
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_wait = idle_draw(in_calm);
      end
      if (!in_tvalid || in_tready) begin
        if (in_wait > 0) begin
          in_wait--;
          in_tvalid <= 1'b0;
        end else if (pair_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, pair_q[0].wb_im, pair_q[0].wb_re, pair_q[0].wa_im,
                       pair_q[0].wa_re, pair_q[0].z_b, pair_q[0].x_b, pair_q[0].z_a,
                       pair_q[0].x_a, pair_q[0].qubits_b, pair_q[0].qubits_a};
          in_tuser <= pair_q[0].func;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (product_q.size() == 0) begin
          $error("result beat arrived with no input pair pending");
          error_count++;
        end else begin
          want = product_q.pop_front();
          check_field("x_out", want.x_out, out_tdata[63:0]);
          check_field("z_out", want.z_out, out_tdata[127:64]);
          check_field("phase_out", 64'(want.phase_out), 64'(out_tdata[129:128]));
          check_field("w_re_out", 64'(want.w_re_out), 64'(out_tdata[161:130]));
          check_field("w_im_out", 64'(want.w_im_out), 64'(out_tdata[193:162]));
          check_field("commutes", 64'(want.commutes), 64'(out_tdata[194]));
          check_field("saturated", 64'(want.saturated), 64'(out_tdata[195]));
          check_field("status", 64'(want.status), 64'(out_tuser));
        end
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_wait = idle_draw(out_calm);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic       func;
    logic [6:0] qa, qb;

    // One- and two-qubit products covering each phase index, then masking and counts.
    add_pair(FUNC_PRODUCT, 1, 1, 0, 0, 0, 0, W_ONE, 0, W_ONE, 0);
    add_pair(FUNC_PRODUCT, 1, 1, 1, 0, 0, 1, W_ONE, 0, W_ONE, 0);
    add_pair(FUNC_PRODUCT, 1, 1, 0, 1, 1, 0, 32'h0002_0000, 32'h0001_8000, W_ONE, W_ONE);
    add_pair(FUNC_PRODUCT, 2, 2, 3, 0, 0, 3, W_ONE, W_ONE, 32'h0000_4000, 32'hffff_c000);
    add_pair(FUNC_PRODUCT, 1, 1, 1, 1, 1, 1, W_MAX, W_MIN, W_ONE, 0);
    add_pair(FUNC_PRODUCT, 64, 64, ONES, ONES, ONES, 0, W_MAX, W_MAX, W_MAX, W_MAX);
    add_pair(FUNC_PRODUCT, 127, 127, ONES, 0, ONES, ONES, W_MIN, W_MIN, W_MIN, W_MIN);
    add_pair(FUNC_PRODUCT, 0, 0, ONES, ONES, ONES, ONES, W_ONE, 0, W_ONE, 0);
    add_pair(FUNC_PRODUCT, 5, 5, 64'hffff_ffff_ffff_ffe5, 64'hf0f0_f0f0_f0f0_f0f3,
             64'h5555_5555_5555_555a, 64'haaaa_aaaa_aaaa_aabc, W_ONE, W_HALF, W_MIN, W_ONE);
    // Qubit count mismatches, including counts that mask alike.
    add_pair(FUNC_PRODUCT, 64, 63, ONES, ONES, ONES, ONES, W_MAX, 0, W_MAX, 0);
    add_pair(FUNC_COMMUTE, 1, 2, 1, 0, 0, 1, W_ONE, 0, W_ONE, 0);
    add_pair(FUNC_PRODUCT, 0, 64, ONES, ONES, ONES, ONES, W_ONE, 0, W_ONE, 0);
    add_pair(FUNC_COMMUTE, 127, 64, ONES, ONES, ONES, ONES, W_ONE, 0, W_ONE, 0);
    // Commutation tests.
    add_pair(FUNC_COMMUTE, 1, 1, 1, 0, 0, 1, W_ONE, 0, W_ONE, 0);
    add_pair(FUNC_COMMUTE, 1, 1, 1, 0, 1, 0, W_ONE, 0, W_ONE, 0);
    add_pair(FUNC_COMMUTE, 64, 64, ONES, ONES, ONES, ONES, W_MAX, W_MIN, W_MIN, W_MAX);
    add_pair(FUNC_COMMUTE, 0, 0, ONES, ONES, ONES, ONES, W_ONE, 0, W_ONE, 0);
    add_pair(FUNC_COMMUTE, 127, 127, ONES, 0, 0, ONES, W_ONE, 0, W_ONE, 0);
    // Negating the most negative weight, in each rotation that does it.
    add_pair(FUNC_PRODUCT, 2, 2, 3, 0, 0, 3, W_MIN, 0, W_ONE, 0);
    add_pair(FUNC_PRODUCT, 1, 1, 1, 0, 0, 1, W_MIN, 0, W_ONE, 0);
    add_pair(FUNC_PRODUCT, 1, 1, 0, 1, 1, 0, 0, W_MIN, W_ONE, 0);
    // Rounding ties on both signs, and sums far out of range.
    add_pair(FUNC_PRODUCT, 1, 1, 0, 0, 0, 0, 32'h0000_0001, 0, W_HALF, 0);
    add_pair(FUNC_PRODUCT, 1, 1, 0, 0, 0, 0, 32'hffff_ffff, 0, W_HALF, 0);
    add_pair(FUNC_PRODUCT, 1, 1, 0, 0, 0, 0, W_MIN, W_MAX, W_MAX, W_MIN);
    add_pair(FUNC_PRODUCT, 1, 1, 0, 0, 0, 0, W_MAX, W_MIN, W_MAX, W_MAX);

    for (int n = 0; n < 1526; n++) begin
      func = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0: qa = 7'($urandom_range(0, 127));
        1, 2, 3: qa = 7'd64;
        default: qa = 7'($urandom_range(1, 64));
      endcase
      qb = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : qa;
      add_pair(func, qa, qb, rand_code(), rand_code(), rand_code(), rand_code(),
               rand_weight(), rand_weight(), rand_weight(), rand_weight());
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (pair_q.size() != 0 || product_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
